[design/swpc_pkg.sv]
// ----------------------------------------------------------------------------
// swpc_pkg
// Shared widths, constants and transaction types of the sliding-window peak
// counter.
// ----------------------------------------------------------------------------
package swpc_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int CFG_W          = 11;
    localparam int PARTS_W        = 10;
    localparam int START_W        = 21;
    localparam int MAX_ITEMS      = 1048576;
    localparam int IDX_W          = $clog2(MAX_ITEMS + 1);
    localparam int MAX_WINDOW_DEF = 1024;
    localparam int MIN_WINDOW     = 3;

    localparam logic [CFG_W-1:0] CFG_WIN_RESET = CFG_W'(MIN_WINDOW);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [PARTS_W-1:0] parts;
        logic [START_W-1:0] start_position;
        logic               too_short;
    } t_out_item;

endpackage

[design/swpc_core.sv]
// ----------------------------------------------------------------------------
// swpc_core
// Per-sample datapath: peak detect, ring of peak flags, running window count
// and best-window tracking. Produces the result in the cycle of the last
// sample.
// ----------------------------------------------------------------------------
module swpc_core
    import swpc_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in_item         i_item,
    input  logic [CFG_W-1:0] i_win_len,
    output logic             o_res_valid,
    output t_out_item        o_res
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int CW = $clog2(MAX_WINDOW);

    logic [SAMPLE_W-1:0] r_older;
    logic [SAMPLE_W-1:0] r_newer;
    logic [IDX_W-1:0]    r_idx;
    logic [KW-1:0]       r_run;
    logic [AW-1:0]       r_wptr;
    logic                r_gone;
    logic [CW-1:0]       r_win;
    logic [CW-1:0]       r_best;
    logic [IDX_W-1:0]    r_bstart;
    logic                r_flag_mem [MAX_WINDOW];

    logic                active;
    logic                has_prev;
    logic                wr_en;
    logic [KW-1:0]       clamp_len;
    logic [KW-1:0]       n_run;
    logic                peak;
    logic [CW-1:0]       win_add;
    logic [CW-1:0]       win_sub;
    logic                in_window;
    logic [IDX_W-1:0]    win_start;
    logic                better;
    logic [AW:0]         rd_diff;
    logic [AW-1:0]       n_raddr;
    logic [AW-1:0]       n_wptr;
    logic [IDX_W-1:0]    n_idx;
    logic [CW-1:0]       n_best;
    logic [IDX_W-1:0]    n_bstart;
    logic [CW:0]         best_inc;
    logic [IDX_W-1:0]    start_inc;
    logic                too_short;

    always_comb begin
        if (32'(i_win_len) < 32'(MIN_WINDOW)) begin
            clamp_len = KW'(MIN_WINDOW);
        end else if (32'(i_win_len) > 32'(MAX_WINDOW)) begin
            clamp_len = KW'(MAX_WINDOW);
        end else begin
            clamp_len = KW'(i_win_len);
        end
    end

    assign active   = (r_idx != IDX_W'(MAX_ITEMS));
    assign has_prev = (r_idx != '0);
    assign wr_en    = i_accept && active && has_prev;
    // latch the window length on the first sample of a sequence
    assign n_run    = (r_idx == '0) ? clamp_len : r_run;

    assign peak = (r_idx >= IDX_W'(2)) && (r_newer > r_older) &&
                  (r_newer > i_item.sample);

    assign win_add   = r_win + CW'(peak);
    assign in_window = has_prev && (r_idx >= (IDX_W'(r_run) - IDX_W'(1)));
    assign win_start = r_idx - IDX_W'(r_run) + IDX_W'(1);

    always_comb begin
        win_sub = win_add;
        if (in_window && r_gone && (win_add != '0)) begin
            win_sub = win_add - CW'(1);
        end
    end

    assign better = in_window && (win_sub > r_best);

    // flag leaving the window on the next sample sits run-3 slots behind
    // the slot written now
    assign rd_diff = {1'b0, r_wptr} - (AW+1)'(r_run - KW'(MIN_WINDOW));
    assign n_raddr = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(MAX_WINDOW)) : rd_diff[AW-1:0];
    assign n_wptr  = (r_wptr == AW'(MAX_WINDOW - 1)) ? '0 : r_wptr + AW'(1);

    assign n_idx    = active ? r_idx + IDX_W'(1) : r_idx;
    assign n_best   = (active && better) ? win_sub : r_best;
    assign n_bstart = (active && better) ? win_start : r_bstart;

    assign best_inc  = {1'b0, n_best} + (CW+1)'(1);
    assign start_inc = n_bstart + IDX_W'(1);
    assign too_short = (n_idx < IDX_W'(n_run));

    assign o_res_valid = i_accept && i_item.last;
    always_comb begin
        if (too_short) begin
            o_res.parts          = PARTS_W'(1);
            o_res.start_position = START_W'(1);
            o_res.too_short      = 1'b1;
        end else begin
            o_res.parts          = PARTS_W'(best_inc);
            o_res.start_position = START_W'(start_inc);
            o_res.too_short      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older  <= '0;
            r_newer  <= '0;
            r_idx    <= '0;
            r_run    <= KW'(MIN_WINDOW);
            r_wptr   <= '0;
            r_win    <= '0;
            r_best   <= '0;
            r_bstart <= '0;
        end else if (i_accept) begin
            if (i_item.last) begin
                // drop the sequence state, the next sample starts fresh
                r_older  <= '0;
                r_newer  <= '0;
                r_idx    <= '0;
                r_run    <= KW'(MIN_WINDOW);
                r_wptr   <= '0;
                r_win    <= '0;
                r_best   <= '0;
                r_bstart <= '0;
            end else if (active) begin
                r_older  <= r_newer;
                r_newer  <= i_item.sample;
                r_idx    <= n_idx;
                r_run    <= n_run;
                r_win    <= win_sub;
                r_best   <= n_best;
                r_bstart <= n_bstart;
                if (has_prev) begin
                    r_wptr <= n_wptr;
                end
            end
        end
    end

    // peak flag ring; prefetch the next outgoing flag, bypass a same-slot write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_flag_mem[r_wptr] <= peak;
            if (n_raddr == r_wptr) begin
                r_gone <= peak;
            end else begin
                r_gone <= r_flag_mem[n_raddr];
            end
        end
    end

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.last) |=> (r_idx == '0) && (r_best == '0) && (r_win == '0))
        else $error("sequence state not cleared after last transaction");

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= AW'(MAX_WINDOW - 1))
        else $error("flag ring write pointer out of range");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (IDX_W'(r_best) <= r_idx) && (IDX_W'(r_win) <= r_idx))
        else $error("peak count exceeds samples seen");

endmodule

[design/swpc_out_buf.sv]
// ----------------------------------------------------------------------------
// swpc_out_buf
// Result register with a skid stage, so a waiting result does not stall the
// sample side until a second result has to wait behind it.
// ----------------------------------------------------------------------------
module swpc_out_buf
    import swpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_space,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_ready
);

    logic      r_main_valid;
    t_out_item r_main;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      pop;

    assign pop     = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid stage holds a result while result register is empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed into a full output buffer");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_skid_valid) |=> (r_main_valid && !r_skid_valid))
        else $error("skid stage did not move into the result register");

endmodule

[design/sliding_window_peak_count.sv]
// ----------------------------------------------------------------------------
// sliding_window_peak_count
// Streams unsigned samples and, on the sample marked last, reports one plus the
// largest count of strict peaks inside any window of the configured length.
//
// Input channel (i_valid / o_ready / i_item): one sample per transaction,
// i_item.last closes the sequence. A sample is taken every cycle while
// o_ready is high; throughput is one sample per clock.
// Output channel (o_valid / i_ready / o_result): one result per sequence,
// registered into the result register, or into the skid stage if that is full.
// The result register plus a one-entry skid stage hold results while the
// receiver stalls; o_ready drops only when both are full.
// Configuration: i_cfg_we writes the window length at once; the length is
// latched on the first sample of each sequence, values are clamped to
// 3..MAX_WINDOW.
// Reset (synchronous, active low) sets the window length to 3, empties the
// output buffer and starts a new sequence. The peak flag ring needs no
// clearing pass: a flag is always written before it is used.
// ----------------------------------------------------------------------------
module sliding_window_peak_count
    import swpc_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_item        o_result,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic [CFG_W-1:0] r_win_len;
    logic             accept;
    logic             res_valid;
    t_out_item        res;
    logic             space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= CFG_WIN_RESET;
        end else if (i_cfg_we) begin
            r_win_len <= i_cfg_wdata;
        end
    end

    assign o_ready = space;
    assign accept  = i_valid && space;

    swpc_core #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_win_len   (r_win_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    swpc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_valid),
        .o_data  (o_result),
        .i_ready (i_ready)
    );

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding-window peak counter. Streams of samples
// go in through a bursty sender while the result side stalls on its own
// pattern. A cycle-level tracker of the peak counts predicts each sequence
// result, and every returned result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import swpc_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 7;
    localparam int IDLE_TAIL   = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 500;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_ZIGZAG,
        SHAPE_NARROW,
        SHAPE_FLAT,
        SHAPE_RAMP
    } t_shape;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    t_in_item         i_item;
    logic             o_valid;
    logic             i_ready;
    t_out_item        o_result;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    sliding_window_peak_count u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Peak tracker state
    logic [CFG_W-1:0]    window_reg = CFG_WIN_RESET;
    logic [SAMPLE_W-1:0] older_smp  = '0;
    logic [SAMPLE_W-1:0] newer_smp  = '0;
    int unsigned         seq_count  = 0;
    int unsigned         win_peaks  = 0;
    int unsigned         best_peaks = 0;
    int unsigned         best_lo    = 0;
    int unsigned         run_len    = MIN_WINDOW;
    bit                  peak_ring [MAX_WINDOW_DEF];

    t_out_item results_due [$];

    int error_count        = 0;
    int results_checked    = 0;
    int short_sequences    = 0;
    int samples_taken      = 0;
    int input_stall_cycles = 0;
    int cycle_count        = 0;

    // Sender and receiver controls
    bit          gaps_on        = 1'b1;
    int          burst_left     = 0;
    bit          rx_stalls_on   = 1'b1;
    int          rx_hold_cycles = 0;
    logic [15:0] rx_pattern     = '1;
    logic [3:0]  rx_phase       = '0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("FAIL sliding_window_peak_count");
            $finish;
        end
    end

    // Receiver: stall on a 16-bit pattern redrawn each pass, or hold off for a counted stretch
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles != 0) begin
                i_ready = 1'b0;
                rx_hold_cycles--;
            end else begin
                if (rx_phase == 0) begin
                    if (!rx_stalls_on)
                        rx_pattern = '1;
                    else if ($urandom_range(0, 1) == 1)
                        rx_pattern = 16'($urandom() | $urandom());
                    else
                        rx_pattern = 16'($urandom());
                end
                i_ready = rx_pattern[rx_phase];
                rx_phase++;
            end
        end
    end

    function automatic void restart_sequence();
        older_smp  = '0;
        newer_smp  = '0;
        seq_count  = 0;
        win_peaks  = 0;
        best_peaks = 0;
        best_lo    = 0;
        run_len    = MIN_WINDOW;
    endfunction

    function automatic void step_peak_counter(input t_in_item item, output bit made,
                                              output t_out_item res);
        bit          is_peak;
        bit          gone;
        int unsigned lo;
        made = 1'b0;
        res  = '0;
        if (seq_count < MAX_ITEMS) begin
            // latch the window length on the first sample of a sequence
            if (seq_count == 0) begin
                if (window_reg < MIN_WINDOW)
                    run_len = MIN_WINDOW;
                else if (window_reg > MAX_WINDOW_DEF)
                    run_len = MAX_WINDOW_DEF;
                else
                    run_len = 32'(window_reg);
            end
            if (seq_count >= 1) begin
                is_peak = (seq_count >= 2) && (newer_smp > older_smp) &&
                          (newer_smp > item.sample);
                peak_ring[(seq_count - 1) % MAX_WINDOW_DEF] = is_peak;
                win_peaks += is_peak;
            end
            // drop the flag of the sample that just became the window's first end
            if (seq_count >= run_len - 1) begin
                lo   = seq_count - run_len + 1;
                gone = peak_ring[lo % MAX_WINDOW_DEF];
                win_peaks = (win_peaks >= gone) ? win_peaks - gone : 0;
                if (win_peaks > best_peaks) begin
                    best_peaks = win_peaks;
                    best_lo    = lo;
                end
            end
            older_smp = newer_smp;
            newer_smp = item.sample;
            seq_count++;
        end
        if (item.last) begin
            made = 1'b1;
            if (seq_count < run_len) begin
                res.parts          = PARTS_W'(1);
                res.start_position = START_W'(1);
                res.too_short      = 1'b1;
            end else begin
                res.parts          = PARTS_W'(best_peaks + 1);
                res.start_position = START_W'(best_lo + 1);
                res.too_short      = 1'b0;
            end
            restart_sequence();
        end
    endfunction

    always @(posedge i_clk) begin : track_and_check
        t_out_item due;
        t_out_item got;
        bit        made;
        if (!i_rst_n) begin
            window_reg = CFG_WIN_RESET;
            restart_sequence();
        end else begin
            if (o_valid && i_ready) begin
                got = o_result;
                if (results_due.size() == 0) begin
                    $error("unexpected result: parts %0d start_position %0d too_short %0d",
                           got.parts, got.start_position, got.too_short);
                    error_count++;
                end else begin
                    due = results_due.pop_front();
                    if (got.parts !== due.parts) begin
                        $error("parts: expected %0d, actual %0d", due.parts, got.parts);
                        error_count++;
                    end
                    if (got.start_position !== due.start_position) begin
                        $error("start_position: expected %0d, actual %0d",
                               due.start_position, got.start_position);
                        error_count++;
                    end
                    if (got.too_short !== due.too_short) begin
                        $error("too_short: expected %0d, actual %0d",
                               due.too_short, got.too_short);
                        error_count++;
                    end
                    results_checked++;
                end
            end
            if (i_valid && o_ready) begin
                step_peak_counter(i_item, made, due);
                samples_taken++;
                if (made) begin
                    results_due = {results_due, due};
                    if (due.too_short)
                        short_sequences++;
                end
            end else if (i_valid) begin
                input_stall_cycles++;
            end
            if (i_cfg_we)
                window_reg = i_cfg_wdata;
        end
    end

    // Offer one sample; returns at the edge where the transaction is taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    @(negedge i_clk);
                    i_valid = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_item.sample = value;
        i_item.last   = is_last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_values(input logic [SAMPLE_W-1:0] vals [$]);
        foreach (vals[i])
            send_sample(vals[i], i == vals.size() - 1);
    endtask

    task automatic send_sequence(input int len, input t_shape shape);
        logic [SAMPLE_W-1:0] value;
        logic [SAMPLE_W-1:0] base;
        base = $urandom();
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_ZIGZAG: begin
                    value = (i % 2) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                    : SAMPLE_W'($urandom_range(0, 3));
                end
                SHAPE_NARROW: begin
                    value = SAMPLE_W'($urandom_range(0, 3));
                end
                SHAPE_FLAT: begin
                    value = base;
                end
                SHAPE_RAMP: begin
                    value = base + SAMPLE_W'(i);
                end
                default: begin
                    value = $urandom();
                end
            endcase
            send_sample(value, i == len - 1);
        end
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic set_window(input int value);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic test_directed_cases();
        logic [SAMPLE_W-1:0] vals [$];
        gaps_on = 1'b0;
        // sequences shorter than the reset window
        vals = '{32'h0};
        send_values(vals);
        vals = '{32'hFFFF_FFFF, 32'h0};
        send_values(vals);
        // one peak, exactly one window
        vals = '{32'h0, 32'hFFFF_FFFF, 32'h0};
        send_values(vals);
        // peaks on both ends never count
        vals = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        send_values(vals);
        // equal neighbors are not strict peaks
        vals = '{32'd7, 32'd7, 32'd7};
        send_values(vals);
        // tie between windows: earliest start wins
        vals = '{32'd1, 32'd2, 32'd1, 32'd2, 32'd1};
        send_values(vals);
        vals = '{32'd3, 32'd2, 32'd1};
        send_values(vals);
        gaps_on = 1'b1;
    endtask

    task automatic test_window_extremes();
        // lengths below the minimum act as 3
        set_window(0);
        send_sequence(2, SHAPE_RANDOM);
        send_sequence(3, SHAPE_ZIGZAG);
        set_window(1);
        send_sequence(3, SHAPE_ZIGZAG);
        set_window(2);
        send_sequence(4, SHAPE_NARROW);
        // lengths above the maximum act as 1024
        set_window(2047);
        send_sequence(30, SHAPE_ZIGZAG);
        set_window(MAX_WINDOW_DEF);
        send_sequence(20, SHAPE_NARROW);
        set_window(MAX_WINDOW_DEF + 1);
        send_sequence(10, SHAPE_ZIGZAG);
        // a longer sequence at the smallest window
        set_window(MIN_WINDOW);
        send_sequence(60, SHAPE_ZIGZAG);
    endtask

    task automatic test_random_streams();
        int sent;
        int win;
        int len;
        sent = 0;
        win  = MIN_WINDOW;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                win = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(3, 16);
                set_window(win);
            end
            gaps_on      = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 3))
                0:       len = $urandom_range(1, win - 1);
                1:       len = $urandom_range(win - 1, win + 2);
                default: len = $urandom_range(win, 2 * win + 4);
            endcase
            send_sequence(len, t_shape'($urandom_range(0, 4)));
            sent += len;
        end
        gaps_on      = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_window(MIN_WINDOW);
        gaps_on = 1'b0;
        @(posedge i_clk);
        rx_hold_cycles = 200;
        // short sequences pile up results until the input stalls
        repeat (10) send_sequence($urandom_range(1, 4), t_shape'($urandom_range(0, 4)));
        wait_results_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        set_window(5);
        gaps_on      = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (6) send_sequence($urandom_range(4, 30), t_shape'($urandom_range(0, 4)));
        gaps_on      = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_window_extremes();
        test_random_streams();
        test_output_backpressure();
        test_steady_stream();

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d results never arrived", results_due.size());
            error_count++;
        end

        $display("Checked %0d results over %0d samples, %0d of them too short for the window.",
                 results_checked, samples_taken, short_sequences);
        $display("Window lengths 0..2047 written; input held off %0d cycles by a full output.",
                 input_stall_cycles);
        if (error_count == 0) begin
            $display("PASS sliding_window_peak_count");
        end else begin
            $display("FAIL sliding_window_peak_count");
        end
        $finish;
    end

endmodule

[files.f]
design/swpc_pkg.sv
design/swpc_core.sv
design/swpc_out_buf.sv
design/sliding_window_peak_count.sv
tb/sv/tb_top.sv
